@@ hdl/ewrs_pkg.sv @@
package ewrs_pkg;

   localparam int WEIGHT_W   = 16;
   localparam int LEVEL_W    = 8;
   localparam int FRAC_W     = 16;
   localparam int SLOT_OUT_W = 4;

   localparam logic ACTION_LOAD = 1'b0;
   localparam logic ACTION_ROLL = 1'b1;

   typedef struct packed {
      logic [WEIGHT_W-1:0] weight;
      logic [LEVEL_W-1:0]  min_level;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SUM  = 4'b0010,
      ST_MUL  = 4'b0100,
      ST_SCAN = 4'b1000
   } walk_state_type;

endpackage

@@ hdl/ewrs_table.sv @@
module ewrs_table
   import ewrs_pkg::*;
#(
   parameter int TABLE_ENTRIES = 16,
   parameter int IDX_W         = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  entry_type        wr_entry,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output entry_type        rd_entry,
   output logic             rd_used
);

   entry_type                  entry_mem_ff [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0]   used_ff;
   entry_type                  rd_entry_ff;
   logic                       rd_used_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[wr_addr] <= wr_entry;
      end
      if (rd_en) begin
         rd_entry_ff <= entry_mem_ff[rd_addr];
         rd_used_ff  <= used_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else if (wr_en) begin
         used_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_entry = rd_entry_ff;
   assign rd_used  = rd_used_ff;

endmodule

@@ hdl/ewrs_walk.sv @@
module ewrs_walk
   import ewrs_pkg::*;
#(
   parameter int TABLE_ENTRIES = 16,
   parameter int IDX_W         = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  roll_go,
   input  logic [LEVEL_W-1:0]    player_level,
   input  logic [FRAC_W-1:0]     random_fraction,
   output logic                  busy,
   output logic                  rd_en,
   output logic [IDX_W-1:0]      rd_addr,
   input  entry_type             rd_entry,
   input  logic                  rd_used,
   output logic                  rsp_strobe,
   output logic                  rsp_found,
   output logic [SLOT_OUT_W-1:0] rsp_selected_index
);

   localparam int TOT_W  = WEIGHT_W + IDX_W;
   localparam int PROD_W = FRAC_W + TOT_W;

   walk_state_type        state_ff, state_in;
   logic [IDX_W:0]        issue_ff, issue_in;
   logic                  pend_ff, pend_in;
   logic [IDX_W-1:0]      pend_addr_ff, pend_addr_in;
   logic [LEVEL_W-1:0]    level_ff, level_in;
   logic [FRAC_W-1:0]     frac_ff, frac_in;
   logic [TOT_W-1:0]      total_ff, total_in;
   logic                  any_ff, any_in;
   logic [IDX_W-1:0]      first_ff, first_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [TOT_W-1:0]      accum_ff, accum_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   logic                  rsp_found_ff, rsp_found_in;
   logic [IDX_W-1:0]      rsp_slot_ff, rsp_slot_in;

   logic                  issuing;
   logic                  eligible;
   logic                  last;
   logic [TOT_W-1:0]      weight_ext;
   logic [TOT_W-1:0]      accum_sum;
   logic [TOT_W-1:0]      roll;
   logic [IDX_W+SLOT_OUT_W-1:0] slot_ext;

   assign issuing    = (state_ff == ST_SUM || state_ff == ST_SCAN) &&
                       (issue_ff < (IDX_W+1)'(TABLE_ENTRIES));
   assign eligible   = pend_ff && rd_used && (rd_entry.min_level <= level_ff);
   assign last       = pend_ff && (pend_addr_ff == IDX_W'(TABLE_ENTRIES - 1));
   assign weight_ext = TOT_W'(rd_entry.weight);
   assign accum_sum  = accum_ff + weight_ext;
   assign roll       = prod_ff[PROD_W-1:FRAC_W];

   always_comb begin
      state_in      = state_ff;
      issue_in      = issue_ff;
      pend_in       = issuing;
      pend_addr_in  = issue_ff[IDX_W-1:0];
      level_in      = level_ff;
      frac_in       = frac_ff;
      total_in      = total_ff;
      any_in        = any_ff;
      first_in      = first_ff;
      prod_in       = prod_ff;
      accum_in      = accum_ff;
      rsp_strobe_in = 1'b0;
      rsp_found_in  = rsp_found_ff;
      rsp_slot_in   = rsp_slot_ff;
      if (issuing) begin
         issue_in = issue_ff + 1'b1;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (roll_go) begin
               state_in = ST_SUM;
               issue_in = '0;
               level_in = player_level;
               frac_in  = random_fraction;
               total_in = '0;
               any_in   = 1'b0;
               first_in = '0;
            end
         end
         ST_SUM: begin
            if (eligible) begin
               total_in = total_ff + weight_ext;
               if (!any_ff) begin
                  any_in   = 1'b1;
                  first_in = pend_addr_ff;
               end
            end
            if (last) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = PROD_W'(frac_ff) * PROD_W'(total_ff);
            issue_in = '0;
            accum_in = '0;
            if (any_ff) begin
               state_in = ST_SCAN;
            end else begin
               state_in      = ST_IDLE;
               rsp_strobe_in = 1'b1;
               rsp_found_in  = 1'b0;
               rsp_slot_in   = '0;
            end
         end
         ST_SCAN: begin
            if (eligible) begin
               accum_in = accum_sum;
            end
            if (eligible && roll <= accum_sum) begin
               state_in      = ST_IDLE;
               rsp_strobe_in = 1'b1;
               rsp_found_in  = 1'b1;
               rsp_slot_in   = pend_addr_ff;
            end else if (last) begin
               state_in      = ST_IDLE;
               rsp_strobe_in = 1'b1;
               rsp_found_in  = 1'b1;
               rsp_slot_in   = first_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      issue_ff     <= issue_in;
      pend_addr_ff <= pend_addr_in;
      level_ff     <= level_in;
      frac_ff      <= frac_in;
      total_ff     <= total_in;
      any_ff       <= any_in;
      first_ff     <= first_in;
      prod_ff      <= prod_in;
      accum_ff     <= accum_in;
      rsp_found_ff <= rsp_found_in;
      rsp_slot_ff  <= rsp_slot_in;
   end

   assign slot_ext           = {{SLOT_OUT_W{1'b0}}, rsp_slot_ff};
   assign busy               = (state_ff != ST_IDLE);
   assign rd_en              = issuing;
   assign rd_addr            = issue_ff[IDX_W-1:0];
   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_selected_index = slot_ext[SLOT_OUT_W-1:0];

endmodule

@@ hdl/eligible_weighted_random_select.sv @@
// channel  | ports                                   | handshake
// ---------+-----------------------------------------+------------------------------
// request  | req_action, req_entry_*, req_player_*,  | beat taken when start && !busy
//          | req_random_fraction                     |
// response | rsp_found, rsp_selected_index           | rsp_strobe, one cycle, no stall
//
// A load beat writes the table in the accepting cycle and never raises busy.
// A roll beat keeps busy high for at most two passes over the single-read-port table
// memory, one read a cycle, plus a multiply step between the passes.
// The response strobe appears in the same cycle that busy falls; a new beat may be taken then.
// Synchronous reset clears the used flags and control state; table contents are kept.
module eligible_weighted_random_select
   import ewrs_pkg::*;
#(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_action,
   input  logic [SLOT_OUT_W-1:0] req_entry_index,
   input  logic [WEIGHT_W-1:0]   req_entry_weight,
   input  logic [LEVEL_W-1:0]    req_entry_min_level,
   input  logic [LEVEL_W-1:0]    req_player_level,
   input  logic [FRAC_W-1:0]     req_random_fraction,
   output logic                  rsp_strobe,
   output logic                  rsp_found,
   output logic [SLOT_OUT_W-1:0] rsp_selected_index
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);

   logic                          accept;
   logic                          load_en;
   logic                          roll_go;
   logic [IDX_W+SLOT_OUT_W-1:0]   index_ext;
   entry_type                     wr_entry;
   logic                          rd_en;
   logic [IDX_W-1:0]              rd_addr;
   entry_type                     rd_entry;
   logic                          rd_used;

   assign accept    = start && !busy;
   assign index_ext = {{IDX_W{1'b0}}, req_entry_index};
   // drop loads aimed beyond the table
   assign load_en   = accept && (req_action == ACTION_LOAD) &&
                      (index_ext < (IDX_W+SLOT_OUT_W)'(TABLE_ENTRIES));
   assign roll_go   = accept && (req_action == ACTION_ROLL);
   assign wr_entry  = '{weight: req_entry_weight, min_level: req_entry_min_level};

   ewrs_table #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .IDX_W         (IDX_W)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (load_en),
      .wr_addr  (index_ext[IDX_W-1:0]),
      .wr_entry (wr_entry),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry),
      .rd_used  (rd_used)
   );

   ewrs_walk #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .IDX_W         (IDX_W)
   ) u_walk (
      .clock              (clock),
      .reset              (reset),
      .roll_go            (roll_go),
      .player_level       (req_player_level),
      .random_fraction    (req_random_fraction),
      .busy               (busy),
      .rd_en              (rd_en),
      .rd_addr            (rd_addr),
      .rd_entry           (rd_entry),
      .rd_used            (rd_used),
      .rsp_strobe         (rsp_strobe),
      .rsp_found          (rsp_found),
      .rsp_selected_index (rsp_selected_index)
   );

endmodule

@@ hdl/ewrs_checker.sv @@
module ewrs_checker
   import ewrs_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic                  req_action,
   input logic                  rsp_strobe,
   input logic                  rsp_found,
   input logic [SLOT_OUT_W-1:0] rsp_selected_index
);

   a_roll_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_action == ACTION_ROLL |=> busy)
      else $error("roll beat did not raise busy");

   a_load_quiet: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_action == ACTION_LOAD |=> !busy && !rsp_strobe)
      else $error("load beat caused activity");

   a_done_strobe: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe)
      else $error("roll ended without a response");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response repeated");

   a_miss_index: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_found |-> rsp_selected_index == '0)
      else $error("index not zero on miss");

endmodule

bind eligible_weighted_random_select ewrs_checker u_ewrs_checker (.*);
